FILE: rtl/address_region_table_defines.svh
// assertion macros for the address region table
`ifndef ADDRESS_REGION_TABLE_DEFINES_SVH
`define ADDRESS_REGION_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define ART_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ART_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ART_ASSERT(lbl, prop, msg)
`define ART_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/art_pkg.sv
// shared types and codes for the address region table
`default_nettype none
package art_pkg;
	localparam int REGION_SLOTS_DEF = 16;

	localparam logic [1:0] REQ_FIND   = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_UNMAP  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_OVERLAP   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [63:0] rstart;
		logic [63:0] rend;
		logic [63:0] flags;
		logic [3:0]  kind;
		logic        cow;
	} entry_t;

	// relations between one stored entry and the request
	typedef struct packed {
		logic s_lt_re;
		logic rs_lt_e;
		logic s_lt_rs;
		logic re_lt_e;
		logic s_eq_rs;
		logic e_eq_re;
		logic a_lt_s;
		logic a_lt_e;
	} cmp_t;
endpackage
`default_nettype wire

FILE: rtl/art_mem.sv
// region entry storage, one write and one registered read port
`default_nettype none
module art_mem #(
	parameter int DEPTH = art_pkg::REGION_SLOTS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire art_pkg::entry_t wr_data,
	input  wire logic [AW-1:0]   rd_addr,
	output art_pkg::entry_t      rd_data
);
	import art_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

FILE: rtl/art_cmp.sv
// compare unit: one stored entry against the request bounds
`default_nettype none
module art_cmp (
	input  wire art_pkg::entry_t ent,
	input  wire logic [63:0]     addr,
	input  wire logic [63:0]     rs,
	input  wire logic [63:0]     re,
	output art_pkg::cmp_t        rel
);
	import art_pkg::*;

	always_comb begin
		rel.s_lt_re = ent.rstart < re;
		rel.rs_lt_e = rs < ent.rend;
		rel.s_lt_rs = ent.rstart < rs;
		rel.re_lt_e = re < ent.rend;
		rel.s_eq_rs = ent.rstart == rs;
		rel.e_eq_re = ent.rend == re;
		rel.a_lt_s  = addr < ent.rstart;
		rel.a_lt_e  = addr < ent.rend;
	end
endmodule
`default_nettype wire

FILE: rtl/address_region_table.sv
// address region table: top level with the scan sequencer
// Each request walks the slot table one entry at a time through a single
// compare unit; an occupied slot is read and then evaluated, a free slot only
// read. Find and remove stop at the first match; add stops at the first overlap,
// else scans all slots; unmap scans twice, once to find an enclosing region and
// a free slot and once to trim, delete or split (only once if the range lies
// inside a region and no slot is free). An empty add or unmap range, or an add
// at zero, is rejected before the scan. The block takes no new transaction until the result has been taken.
`default_nettype none
module address_region_table #(
	parameter int REGION_SLOTS = art_pkg::REGION_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] query_addr,
	input  wire logic [63:0] range_start,
	input  wire logic [63:0] range_end,
	input  wire logic [63:0] new_flags,
	input  wire logic [3:0]  new_kind,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [63:0]      hit_start,
	output logic [63:0]      hit_end,
	output logic [63:0]      hit_flags,
	output logic [3:0]       hit_kind,
	output logic             hit_cow
);
	import art_pkg::*;
	`include "address_region_table_defines.svh"

	localparam int IW = $clog2(REGION_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(REGION_SLOTS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_WR2  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]              state_q;
	logic [REGION_SLOTS-1:0] valid_q;
	logic [IW-1:0]           idx_q, free_q;
	logic                    free_vld_q, encl_q, ph_q;
	logic [1:0]              req_q;
	logic [63:0]             addr_q, rs_q, re_q, flags_q;
	logic [3:0]              kind_q;

	entry_t rd_data, wr_data;
	logic   wr_en;
	logic [IW-1:0] wr_addr;
	cmp_t   rel;

	art_mem #(.DEPTH(REGION_SLOTS), .AW(IW)) u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(idx_q), .rd_data(rd_data)
	);

	art_cmp u_cmp (
		.ent(rd_data), .addr(addr_q), .rs(rs_q), .re(re_q), .rel(rel)
	);

	logic ovl, cover_l, cover_r, encl, fhit, rhit;
	always_comb begin
		ovl     = rel.s_lt_re && rel.rs_lt_e;
		cover_l = !rel.s_lt_rs;
		cover_r = !rel.re_lt_e;
		encl    = rel.s_lt_rs && rel.re_lt_e;
		fhit    = !rel.a_lt_s && rel.a_lt_e;
		rhit    = rel.s_eq_rs && rel.e_eq_re;
	end

	// entry writes: trims and split in the second unmap pass, add at the end
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		case (state_q)
			S_EV: begin
				if (req_q == REQ_UNMAP && ph_q && ovl && !(cover_l && cover_r)) begin
					wr_en = 1'b1;
					if (cover_l) begin
						wr_data.rstart = re_q;
					end else begin
						wr_data.rend = rs_q;
					end
				end
			end
			S_WR2: begin
				wr_en          = 1'b1;
				wr_addr        = free_q;
				wr_data.rstart = re_q;
			end
			S_FIN: begin
				if (req_q == REQ_ADD && free_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = free_q;
					wr_data = '{rstart: rs_q, rend: re_q, flags: flags_q,
						kind: kind_q, cow: 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			idx_q      <= '0;
			free_q     <= '0;
			free_vld_q <= 1'b0;
			encl_q     <= 1'b0;
			ph_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_CHK;
						idx_q      <= '0;
						free_vld_q <= 1'b0;
						encl_q     <= 1'b0;
						ph_q       <= 1'b0;
					end
				end
				S_CHK: begin
					if ((req_q == REQ_ADD || req_q == REQ_UNMAP) &&
						(re_q <= rs_q || (req_q == REQ_ADD && rs_q == '0))) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (valid_q[idx_q] && !(ph_q && encl_q && idx_q == free_q)) begin
						state_q <= S_EV;
					end else begin
						if (!valid_q[idx_q] && !free_vld_q && !ph_q) begin
							free_q     <= idx_q;
							free_vld_q <= 1'b1;
						end
						if (idx_q == LAST) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_EV: begin
					if ((req_q == REQ_FIND && fhit) || (req_q == REQ_ADD && ovl)) begin
						state_q <= S_DONE;
					end else if (req_q == REQ_REMOVE && rhit) begin
						valid_q[idx_q] <= 1'b0;
						state_q        <= S_DONE;
					end else if (req_q == REQ_UNMAP && ph_q && ovl && cover_l && cover_r) begin
						valid_q[idx_q] <= 1'b0;
						state_q <= (idx_q == LAST) ? S_FIN : S_RD;
						idx_q   <= idx_q + 1'b1;
					end else if (req_q == REQ_UNMAP && ph_q && ovl && !cover_l && !cover_r) begin
						valid_q[free_q] <= 1'b1;
						state_q         <= S_WR2;
					end else begin
						if (req_q == REQ_UNMAP && !ph_q && encl) begin
							encl_q <= 1'b1;
						end
						state_q <= (idx_q == LAST) ? S_FIN : S_RD;
						idx_q   <= idx_q + 1'b1;
					end
				end
				S_WR2: begin
					state_q <= (idx_q == LAST) ? S_FIN : S_RD;
					idx_q   <= idx_q + 1'b1;
				end
				S_FIN: begin
					if (req_q == REQ_ADD && free_vld_q) begin
						valid_q[free_q] <= 1'b1;
					end
					if (req_q == REQ_UNMAP && !ph_q && !(encl_q && !free_vld_q)) begin
						ph_q    <= 1'b1;
						idx_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q     <= req_type;
				addr_q    <= query_addr;
				rs_q      <= range_start;
				re_q      <= range_end;
				flags_q   <= new_flags;
				kind_q    <= new_kind;
				status    <= ST_OK;
				hit_start <= '0;
				hit_end   <= '0;
				hit_flags <= '0;
				hit_kind  <= '0;
				hit_cow   <= 1'b0;
			end
			S_CHK: status <= ST_INVALID;
			S_EV: begin
				if (req_q == REQ_FIND && fhit) begin
					status    <= ST_OK;
					hit_start <= rd_data.rstart;
					hit_end   <= rd_data.rend;
					hit_flags <= rd_data.flags;
					hit_kind  <= rd_data.kind;
					hit_cow   <= rd_data.cow;
				end else if (req_q == REQ_ADD && ovl) begin
					status <= ST_OVERLAP;
				end else if (req_q == REQ_REMOVE && rhit) begin
					status <= ST_OK;
				end
			end
			S_FIN: begin
				case (req_q)
					REQ_FIND, REQ_REMOVE: status <= ST_NOT_FOUND;
					REQ_ADD: begin
						if (free_vld_q) begin
							status    <= ST_OK;
							hit_start <= rs_q;
							hit_end   <= re_q;
							hit_flags <= flags_q;
							hit_kind  <= kind_q;
						end else begin
							status <= ST_FULL;
						end
					end
					default: status <= (!ph_q && encl_q && !free_vld_q) ? ST_FULL : ST_OK;
				endcase
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	`ART_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready while busy")
	`ART_NEVER(a_write_idle, wr_en && (state_q == S_IDLE || state_q == S_DONE), "write when idle")
	`ART_ASSERT(a_split_has_slot, (state_q == S_WR2) |-> (encl_q && free_vld_q), "split without slot")
endmodule
`default_nettype wire
